[sv/dtu_pkg.sv]
// dtu_pkg: types and constants for the decimal text to u64 checker.
// Shared by the parse step, the top level and the testbench.
// No dependencies.
`default_nettype none

package dtu_pkg;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_BAD    = 3'd4
    } phase_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // (2^64-1) / 10 and (2^64-1) % 10
    localparam logic [63:0] ACC_MAX_DIV = 64'h1999_9999_9999_9999;
    localparam logic [3:0]  ACC_MAX_MOD = 4'd5;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } in_item_t;

    typedef struct packed {
        logic        well_formed;
        logic        is_negative;
        logic        too_large;
        logic [63:0] magnitude;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic        minus_seen;
        logic        overflowed;
        logic [63:0] acc;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:      PH_LEAD,
        minus_seen: 1'b0,
        overflowed: 1'b0,
        acc:        64'd0
    };

endpackage

`default_nettype wire

[sv/dtu_stream_if.sv]
// dtu_stream_if: valid/ready channel carrying one payload item per transfer.
// Payload type is a parameter; the types come from dtu_pkg.
`default_nettype none

interface dtu_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/decimal_text_to_u64_checker_unit.sv]
// decimal_text_to_u64_checker_unit: top level of the decimal text checker.
// Depends on dtu_pkg, dtu_stream_if and dtu_step.
//
// Usage:
//   in_ch  (sink):   one transfer per text byte (ch, is_end = 0), and a final
//                    transfer with is_end = 1 that closes the text.
//   out_res (source): one result per closing transfer: well_formed,
//                    is_negative, too_large and the 64-bit magnitude. For
//                    malformed text the last three are zero.
// Throughput: one input transfer every cycle while no result waits. Each byte updates the parse
//   state in the cycle it is taken (a times-ten-plus-digit add and an overflow check).
// Latency: the result is valid the cycle after the end marker transfer.
// Stall: the result register holds while out_res.ready is low; in_ch.ready
//   is high only while that register is empty or drained in the same cycle,
//   so while a result waits no byte is taken.
// Reset: rst_n clears the parse state to leading blanks with a zero
//   accumulator and drops the result valid.
`default_nettype none

module decimal_text_to_u64_checker_unit
    import dtu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dtu_stream_if.sink   in_ch,
    dtu_stream_if.source out_res
);

    parse_state_t state_reg;
    parse_state_t step_next;
    logic         out_valid_reg;
    out_item_t    out_data_reg;
    in_item_t     in_item;
    logic         in_xfer;
    logic         out_xfer;
    logic         result_ok;

    assign in_item      = in_ch.data;
    assign in_ch.ready  = !out_valid_reg || out_res.ready;
    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign out_xfer     = out_valid_reg && out_res.ready;
    assign out_res.valid = out_valid_reg;
    assign out_res.data  = out_data_reg;

    assign result_ok = (state_reg.phase == PH_DIGITS) || (state_reg.phase == PH_TRAIL);

    dtu_step u_step (
        .cur (state_reg),
        .ch  (in_item.ch),
        .nxt (step_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PARSE_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (in_xfer && in_item.is_end)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
            if (in_xfer)
            begin
                if (in_item.is_end)
                begin
                    out_data_reg.well_formed <= result_ok;
                    out_data_reg.is_negative <= result_ok && state_reg.minus_seen;
                    out_data_reg.too_large   <= result_ok && state_reg.overflowed;
                    out_data_reg.magnitude   <= result_ok ? state_reg.acc : 64'd0;
                    state_reg                <= PARSE_RESET;
                end
                else
                    state_reg <= step_next;
            end
        end
    end

    // A result only appears after an end marker transfer.
    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_xfer && in_item.is_end))
        else $error("result valid without end marker transfer");

    // Malformed text reports zero sign, overflow and magnitude.
    a_bad_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.well_formed) |->
            (!out_data_reg.is_negative && !out_data_reg.too_large &&
             out_data_reg.magnitude == 64'd0))
        else $error("malformed result carries nonzero fields");

    // End marker returns the parse to its initial state.
    a_end_resets_parse: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_item.is_end) |=>
            (state_reg.phase == PH_LEAD && state_reg.acc == 64'd0 &&
             !state_reg.overflowed && !state_reg.minus_seen))
        else $error("parse state not cleared after end marker");

    // Once overflowed, further bytes keep the flag and freeze the value.
    a_overflow_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !in_item.is_end && state_reg.overflowed) |=>
            (state_reg.overflowed && $stable(state_reg.acc)))
        else $error("overflow flag or held value changed");

endmodule

`default_nettype wire

[sv/dtu_step.sv]
// dtu_step: next parse state for one text byte (blanks, sign, digits, blanks)
// including the times-ten-plus-digit accumulate with overflow hold.
// Depends on dtu_pkg.
`default_nettype none

module dtu_step
    import dtu_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   ch,
    output parse_state_t nxt
);

    logic        blank_hit;
    logic        is_digit;
    logic        is_sign;
    logic [3:0]  digit;
    logic        will_overflow;
    logic [63:0] acc_times_ten;
    parse_state_t with_digit;

    assign blank_hit = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                       (ch == CH_CR) || (ch == CH_VT) || (ch == CH_FF);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign digit    = 4'(ch - CH_ZERO);

    assign will_overflow = (cur.acc > ACC_MAX_DIV) ||
                           ((cur.acc == ACC_MAX_DIV) && (digit > ACC_MAX_MOD));
    assign acc_times_ten = (cur.acc << 3) + (cur.acc << 1);

    // state after taking a digit; value frozen once overflow is flagged
    always_comb
    begin
        with_digit       = cur;
        with_digit.phase = PH_DIGITS;
        if (!cur.overflowed)
        begin
            if (will_overflow)
                with_digit.overflowed = 1'b1;
            else
                with_digit.acc = acc_times_ten + {60'd0, digit};
        end
    end

    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_LEAD:
            begin
                if (blank_hit)
                    nxt = cur;
                else if (is_sign)
                begin
                    nxt.minus_seen = (ch == CH_MINUS);
                    nxt.phase      = PH_SIGN;
                end
                else if (is_digit)
                    nxt = with_digit;
                else
                    nxt.phase = PH_BAD;
            end
            PH_SIGN:
            begin
                if (is_digit)
                    nxt = with_digit;
                else
                    nxt.phase = PH_BAD;
            end
            PH_DIGITS:
            begin
                if (is_digit)
                    nxt = with_digit;
                else if (blank_hit)
                    nxt.phase = PH_TRAIL;
                else
                    nxt.phase = PH_BAD;
            end
            PH_TRAIL:
            begin
                if (!blank_hit)
                    nxt.phase = PH_BAD;
            end
            default:
                nxt.phase = PH_BAD;
        endcase
    end

endmodule

`default_nettype wire

[dv/decimal_text_to_u64_checker_unit_tb.sv]
// Testbench for decimal_text_to_u64_checker_unit: streams text bytes and end
// markers, predicts each verdict in the bench and checks it field by field.
// Depends on dtu_pkg, dtu_stream_if and the RTL of the unit.
module decimal_text_to_u64_checker_unit_tb;
    import dtu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 950;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 300;

    localparam logic [7:0] BLANK_SET [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    logic clk;
    logic rst_n;

    dtu_stream_if #(.data_t(in_item_t))  in_ch ();
    dtu_stream_if #(.data_t(out_item_t)) out_res ();

    decimal_text_to_u64_checker_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_res (out_res)
    );

    // stimulus waiting to be offered, and verdicts waiting to come out
    in_item_t  text_items [$];
    out_item_t expected_verdicts [$];

    // bench copy of the parse state
    phase_t      parse_phase;
    logic        parse_minus;
    logic        parse_overflow;
    logic [63:0] parse_value;

    logic in_taken;
    int   error_count;
    int   idle_cycles;
    int   verdicts_checked;
    int   send_gap;
    int   send_burst;
    int   recv_stall;
    int   recv_burst;
    int   hold_left;
    bit   hold_done;

    function automatic bit blank_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR
            || c == CH_VT || c == CH_FF;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // times ten plus digit; on overflow the value freezes at the last fit
    task automatic accumulate_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (!parse_overflow) begin
            if (parse_value > ACC_MAX_DIV
                || (parse_value == ACC_MAX_DIV && d > 64'(ACC_MAX_MOD)))
                parse_overflow = 1'b1;
            else
                parse_value = parse_value * 64'd10 + d;
        end
    endtask

    task automatic clear_parse();
        parse_phase    = PH_LEAD;
        parse_minus    = 1'b0;
        parse_overflow = 1'b0;
        parse_value    = 64'd0;
    endtask

    task automatic predict_verdict(input in_item_t item);
        out_item_t verdict;
        logic      ok;
        if (item.is_end) begin
            ok = (parse_phase == PH_DIGITS) || (parse_phase == PH_TRAIL);
            verdict.well_formed = ok;
            verdict.is_negative = ok && parse_minus;
            verdict.too_large   = ok && parse_overflow;
            verdict.magnitude   = ok ? parse_value : 64'd0;
            expected_verdicts.push_back(verdict);
            clear_parse();
        end else begin
            case (parse_phase)
                PH_LEAD: begin
                    if (blank_char(item.ch)) begin
                    end else if (item.ch == CH_PLUS || item.ch == CH_MINUS) begin
                        parse_minus = (item.ch == CH_MINUS);
                        parse_phase = PH_SIGN;
                    end else if (is_digit(item.ch)) begin
                        accumulate_digit(item.ch);
                        parse_phase = PH_DIGITS;
                    end else begin
                        parse_phase = PH_BAD;
                    end
                end
                PH_SIGN: begin
                    if (is_digit(item.ch)) begin
                        accumulate_digit(item.ch);
                        parse_phase = PH_DIGITS;
                    end else begin
                        parse_phase = PH_BAD;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit(item.ch))
                        accumulate_digit(item.ch);
                    else if (blank_char(item.ch))
                        parse_phase = PH_TRAIL;
                    else
                        parse_phase = PH_BAD;
                end
                PH_TRAIL: begin
                    if (!blank_char(item.ch))
                        parse_phase = PH_BAD;
                end
                default: parse_phase = PH_BAD;
            endcase
        end
    endtask

    task automatic add_byte(input logic [7:0] c);
        text_items.push_back('{ch: c, is_end: 1'b0});
    endtask

    // ch is don't-care on the end marker, so it gets random bits
    task automatic add_end();
        text_items.push_back('{ch: 8'($urandom_range(0, 255)), is_end: 1'b1});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_digits(input int n);
        for (int i = 0; i < n; i++)
            add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_blanks(input int n);
        for (int i = 0; i < n; i++)
            add_byte(BLANK_SET[$urandom_range(0, 5)]);
    endtask

    // stimulus driver: one item per transfer, random gaps between them
    always @(negedge clk) begin : drive_text
        logic     nxt_valid;
        in_item_t nxt_data;
        int       r;
        nxt_valid = in_ch.valid;
        nxt_data  = in_ch.data;
        if (rst_n) begin
            if (in_ch.valid && in_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (text_items.size() > 0) begin
                    nxt_data  = text_items.pop_front();
                    nxt_valid = 1'b1;
                    if (send_burst > 0) begin
                        send_burst--;
                        send_gap = 0;
                    end else begin
                        r = $urandom_range(0, 99);
                        if (r < 5) begin
                            send_burst = $urandom_range(20, 80);
                            send_gap   = 0;
                        end else if (r < 55) begin
                            send_gap = 0;
                        end else if (r < 90) begin
                            send_gap = $urandom_range(1, 3);
                        end else begin
                            send_gap = $urandom_range(8, 40);
                        end
                    end
                end
            end
        end
        in_ch.valid <= nxt_valid;
        in_ch.data  <= nxt_data;
    end

    // result receiver: random stalls plus one long hold-off to back up the input
    always @(negedge clk) begin : drive_ready
        logic nxt_ready;
        int   r;
        nxt_ready = 1'b0;
        if (rst_n) begin
            if (!hold_done && verdicts_checked >= 30) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (recv_stall > 0) begin
                recv_stall--;
            end else begin
                nxt_ready = 1'b1;
                if (recv_burst > 0) begin
                    recv_burst--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        recv_burst = $urandom_range(20, 80);
                    else if (r < 25)
                        recv_stall = $urandom_range(1, 3);
                    else if (r < 30)
                        recv_stall = $urandom_range(10, 40);
                end
            end
        end
        out_res.ready <= nxt_ready;
    end

    // monitor: checks each result transfer, then predicts from the input transfer
    always @(posedge clk) begin : monitor
        out_item_t want;
        out_item_t got;
        if (!rst_n) begin
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_res.valid && out_res.ready) begin
                got = out_res.data;
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result: magnitude %0d", got.magnitude);
                    error_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.well_formed !== want.well_formed) begin
                        $error("well_formed: expected %0d, actual %0d",
                               want.well_formed, got.well_formed);
                        error_count++;
                    end
                    if (got.is_negative !== want.is_negative) begin
                        $error("is_negative: expected %0d, actual %0d",
                               want.is_negative, got.is_negative);
                        error_count++;
                    end
                    if (got.too_large !== want.too_large) begin
                        $error("too_large: expected %0d, actual %0d",
                               want.too_large, got.too_large);
                        error_count++;
                    end
                    if (got.magnitude !== want.magnitude) begin
                        $error("magnitude: expected %0d, actual %0d",
                               want.magnitude, got.magnitude);
                        error_count++;
                    end
                end
                verdicts_checked++;
            end
            if (in_ch.valid && in_ch.ready)
                predict_verdict(in_ch.data);
            if ((in_ch.valid && in_ch.ready) || (out_res.valid && out_res.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : main
        int kind;
        int sign;
        int span;
        int n;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data       = '0;
        out_res.ready    = 1'b0;
        in_taken         = 1'b0;
        error_count      = 0;
        idle_cycles      = 0;
        verdicts_checked = 0;
        send_gap         = 0;
        send_burst       = 0;
        recv_stall       = 0;
        recv_burst       = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        clear_parse();

        // directed: empty text
        add_end();
        // blank, plus sign, digit, tab trailer
        add_byte(CH_SPACE); add_byte(CH_PLUS); add_byte(CH_ZERO + 8'd7); add_byte(CH_TAB);
        text_items.push_back('{ch: 8'hFF, is_end: 1'b1});
        // lone sign
        add_byte(CH_MINUS); add_end();
        // blank between sign and digit
        add_byte(CH_MINUS); add_byte(CH_SPACE); add_byte(CH_ZERO + 8'd5); add_end();
        // zero byte after a digit
        add_byte(CH_NINE); add_byte(8'h00); add_end();
        // blanks only
        add_byte(CH_VT); add_byte(CH_FF); add_end();
        // non-blank after the trailing blanks
        add_byte(CH_ZERO + 8'd3); add_byte(CH_CR); add_byte(CH_MINUS); add_end();

        n = text_items.size();
        while (text_items.size() < n + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                add_blanks($urandom_range(0, 3));
                sign = $urandom_range(0, 2);
                if (sign == 1)
                    add_byte(CH_PLUS);
                else if (sign == 2)
                    add_byte(CH_MINUS);
                span = $urandom_range(0, 9);
                if (span < 6) begin
                    add_digits($urandom_range(1, 6));
                end else if (span < 8) begin
                    add_digits($urandom_range(17, 22));
                end else begin
                    // around 2^64-1: last digit 5 fits, 6..9 overflow
                    add_text("1844674407370955161");
                    add_digits($urandom_range(1, 3));
                end
                add_blanks($urandom_range(0, 2));
                if (kind >= 60)
                    add_byte(8'($urandom_range(0, 255)));
            end else begin
                span = $urandom_range(0, 5);
                for (int i = 0; i < span; i++) begin
                    case ($urandom_range(0, 3))
                        0: add_digits(1);
                        1: add_blanks(1);
                        2: add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                        default: add_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            add_end();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (text_items.size() != 0 || in_ch.valid || expected_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[filelist.f]
sv/dtu_pkg.sv
sv/dtu_stream_if.sv
sv/dtu_step.sv
sv/decimal_text_to_u64_checker_unit.sv
dv/decimal_text_to_u64_checker_unit_tb.sv
